// ===== hdl/cas_pkg.sv =====
// Shared types, constants and cell-rule functions for the cave automaton step.
// Used by every module of the block and by its checker; depends on nothing.
package cas_pkg;

	localparam int ROW_W      = 32;  // width of the row ports
	localparam int LIMIT_W    = 4;   // width of the limit registers
	localparam int CFG_IDX_W  = 2;   // width of the register index
	localparam int CNT_W      = 4;   // holds a neighbor count of 0..8
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEATH_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LIMIT = 2'd1;

	localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd3;
	localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;

	// Per-item control that the sequencer hands to every cell.
	typedef struct packed {
		logic load;     // an input transaction is accepted this cycle
		logic clear;    // the accepted row is the bottom row
		logic fresh;    // the accepted row starts a new map
		logic top_sel;  // the held row is the top row of the map
	} cell_ctl_t;

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic             final_row;
	} result_t;

	// Window bit 0 is the left neighbor column, bit 1 the own column, bit 2 the right one.
	function automatic logic [CNT_W-1:0] count8(input logic [2:0] above,
			input logic mid_l, input logic mid_r, input logic [2:0] below);
		logic [CNT_W-1:0] sum;
		sum = CNT_W'(above[0]) + CNT_W'(above[1]) + CNT_W'(above[2])
			+ CNT_W'(mid_l) + CNT_W'(mid_r)
			+ CNT_W'(below[0]) + CNT_W'(below[1]) + CNT_W'(below[2]);
		return sum;
	endfunction

	function automatic logic next_cell(input logic [2:0] above, input logic [2:0] mid,
			input logic [2:0] below, input logic [LIMIT_W-1:0] death_limit,
			input logic [LIMIT_W-1:0] birth_limit);
		logic [CNT_W-1:0] cnt;
		cnt = count8(above, mid[0], mid[2], below);
		return mid[1] ? (cnt >= death_limit) : (cnt > birth_limit);
	endfunction

endpackage

// ===== hdl/cave_automaton_step.sv =====
// Cave automaton step: computes one generation of a cave-style cellular automaton
// over a map streamed one row per transaction, top to bottom. Off-map neighbors
// count as alive. A row is taken whenever the queue has two free entries; its
// results land in a four-entry output queue the next cycle, once the row below (or
// the bottom row itself) is accepted. A bottom row that follows a held row gives
// two results, which drain at one per cycle while out_ready is high. Configuration
// writes are taken in any cycle. Depends on cas_pkg, cas_cell and cas_outq.
module cave_automaton_step #(
	parameter int ROW_CELLS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cas_pkg::LIMIT_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cas_pkg::ROW_W-1:0]       cells_in,
	input  logic                            first_row,
	input  logic                            last_row,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cas_pkg::ROW_W-1:0]       cells_out,
	output logic                            final_row
);
	import cas_pkg::*;

	logic [LIMIT_W-1:0]   death_limit_q;
	logic [LIMIT_W-1:0]   birth_limit_q;
	logic                 mid_valid_q;
	logic                 mid_top_q;
	logic                 accept;
	logic                 room2;
	cell_ctl_t            ctl;

	logic [ROW_CELLS-1:0] cur_row;
	logic [ROW_CELLS-1:0] above_bits;
	logic [ROW_CELLS-1:0] mid_bits;
	logic [ROW_CELLS-1:0] res_held;
	logic [ROW_CELLS-1:0] res_cur;
	logic [ROW_CELLS+1:0] above_pad;
	logic [ROW_CELLS+1:0] mid_pad;
	logic [ROW_CELLS+1:0] cur_pad;
	logic [ROW_W-1:0]     held_w;
	logic [ROW_W-1:0]     cur_w;
	result_t              data0;
	result_t              data1;
	result_t              out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			death_limit_q <= DEATH_LIMIT_RST;
			birth_limit_q <= BIRTH_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEATH_LIMIT: death_limit_q <= cfg_data;
				REG_BIRTH_LIMIT: birth_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = room2;
	assign accept   = in_valid && in_ready;

	assign ctl.load    = accept;
	assign ctl.clear   = last_row;
	// A row with no held row above it starts a new map.
	assign ctl.fresh   = first_row || !mid_valid_q;
	assign ctl.top_sel = mid_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_valid_q <= 1'b0;
			mid_top_q   <= 1'b0;
		end else if (accept) begin
			if (last_row) begin
				mid_valid_q <= 1'b0;
				mid_top_q   <= 1'b0;
			end else begin
				mid_valid_q <= 1'b1;
				mid_top_q   <= ctl.fresh;
			end
		end
	end

	// Map columns beyond the ports read as dead; columns off the map sides read as alive.
	for (genvar k = 0; k < ROW_CELLS; k++) begin : g_cur
		if (k < ROW_W) begin : g_in
			assign cur_row[k] = cells_in[k];
		end else begin : g_zero
			assign cur_row[k] = 1'b0;
		end
	end

	assign above_pad = {1'b1, above_bits, 1'b1};
	assign mid_pad   = {1'b1, mid_bits, 1'b1};
	assign cur_pad   = {1'b1, cur_row, 1'b1};

	for (genvar k = 0; k < ROW_CELLS; k++) begin : g_cell
		cas_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.death_limit (death_limit_q),
			.birth_limit (birth_limit_q),
			.above_win   (above_pad[k+2:k]),
			.mid_win     (mid_pad[k+2:k]),
			.cur_win     (cur_pad[k+2:k]),
			.above_bit   (above_bits[k]),
			.mid_bit     (mid_bits[k]),
			.res_held    (res_held[k]),
			.res_cur     (res_cur[k])
		);
	end

	for (genvar k = 0; k < ROW_W; k++) begin : g_out
		if (k < ROW_CELLS) begin : g_res
			assign held_w[k] = res_held[k];
			assign cur_w[k]  = res_cur[k];
		end else begin : g_zero
			assign held_w[k] = 1'b0;
			assign cur_w[k]  = 1'b0;
		end
	end

	// Results are packed: the held row's result, when there is one, goes first.
	assign data0.cells     = ctl.fresh ? cur_w : held_w;
	assign data0.final_row = ctl.fresh;
	assign data1.cells     = cur_w;
	assign data1.final_row = 1'b1;

	cas_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (accept && (!ctl.fresh || last_row)),
		.data0     (data0),
		.push1     (accept && !ctl.fresh && last_row),
		.data1     (data1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign cells_out = out_data.cells;
	assign final_row = out_data.final_row;

endmodule

// ===== hdl/cas_cell.sv =====
// One column cell of the automaton: holds its bit of the two previous rows and
// computes its bit of both possible results. Depends on cas_pkg.
module cas_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cas_pkg::cell_ctl_t           ctl,
	input  logic [cas_pkg::LIMIT_W-1:0]  death_limit,
	input  logic [cas_pkg::LIMIT_W-1:0]  birth_limit,
	input  logic [2:0]                   above_win,
	input  logic [2:0]                   mid_win,
	input  logic [2:0]                   cur_win,
	output logic                         above_bit,
	output logic                         mid_bit,
	output logic                         res_held,
	output logic                         res_cur
);
	import cas_pkg::*;

	logic       above_q;
	logic       mid_q;
	logic [2:0] held_above;
	logic [2:0] cur_above;

	// Off-map rows read as all alive.
	assign held_above = ctl.top_sel ? 3'b111 : above_win;
	assign cur_above  = ctl.fresh ? 3'b111 : mid_win;

	assign res_held = next_cell(held_above, mid_win, cur_win, death_limit, birth_limit);
	assign res_cur  = next_cell(cur_above, cur_win, 3'b111, death_limit, birth_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b1;
			mid_q   <= 1'b0;
		end else if (ctl.load) begin
			if (ctl.clear) begin
				above_q <= 1'b1;
				mid_q   <= 1'b0;
			end else begin
				above_q <= ctl.fresh ? 1'b1 : mid_q;
				mid_q   <= cur_win[1];
			end
		end
	end

	assign above_bit = above_q;
	assign mid_bit   = mid_q;

endmodule

// ===== hdl/cas_outq.sv =====
// Result queue of the automaton: takes up to two results a cycle, hands out one.
// Depends on cas_pkg.
module cas_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  cas_pkg::result_t  data0,
	input  logic              push1,
	input  cas_pkg::result_t  data1,
	output logic              room2,
	output logic              out_valid,
	input  logic              out_ready,
	output cas_pkg::result_t  out_data
);
	import cas_pkg::*;

	result_t                 mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   wr_ptr_q;
	logic [OUTQ_PTR_W-1:0]   rd_ptr_q;
	logic [OUTQ_CNT_W-1:0]   count_q;
	logic                    pop;
	logic [OUTQ_CNT_W-1:0]   n_push;

	assign pop    = out_valid && out_ready;
	assign n_push = OUTQ_CNT_W'(push0) + OUTQ_CNT_W'(push1);

	// Two free entries are needed before a transaction, since one row can yield two results.
	assign room2     = count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= data0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + OUTQ_PTR_W'(1)] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[OUTQ_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - OUTQ_CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/cas_checker.sv =====
// Port-level checker for cave_automaton_step, attached to it by the bind below.
// Depends on cas_pkg.
module cas_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            last_row,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cas_pkg::ROW_W-1:0]       cells_out,
	input logic                            final_row
);
	import cas_pkg::*;

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cells_out) && $stable(final_row))
		else $error("stalled result changed or was withdrawn");

	// Input back-pressure only comes from results waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// A bottom row always yields a result in the next cycle.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_row |=> out_valid)
		else $error("bottom row produced no result");

	// Configuration is never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind cave_automaton_step cas_checker u_cas_checker (.*);

// ===== test/tb_cave_automaton_step.sv =====
// Self-checking testbench for cave_automaton_step: directed rows, then random maps under
// several limit settings and handshake idling patterns, checked against a local predictor.
// Depends on cas_pkg and the cave_automaton_step RTL.
`timescale 1ns / 1ps

module tb_cave_automaton_step;
	import cas_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 127;
	localparam int NUM_DIRECTED = 15;
	localparam int HOLD_CYCLES = 80;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register at this index

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic             first;
		logic             last;
		logic             typed;      // expected result is given in the row itself
		logic [ROW_W-1:0] exp_cells;
		logic             exp_final;
	} row_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [LIMIT_W-1:0]    cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [ROW_W-1:0]      cells_in;
	logic                  first_row;
	logic                  last_row;
	logic                  out_valid;
	logic                  out_ready;
	logic [ROW_W-1:0]      cells_out;
	logic                  final_row;

	// Predictor state.
	logic [LIMIT_W-1:0] lim_death;
	logic [LIMIT_W-1:0] lim_birth;
	logic [ROW_W-1:0]   row_up;
	logic [ROW_W-1:0]   row_held;
	logic               held_ok;
	logic               held_top;

	result_t pending_rows [$];
	int      mismatches;
	int      cycles;
	int      in_idle_pct;
	int      out_stall_pct;
	logic    hold_req;
	logic    long_hold;

	row_item_t directed_rows [NUM_DIRECTED] = '{
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
		'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
		'{32'h1357_9BDF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h8000_0001, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
		'{32'h8000_0001, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
		'{32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
		'{32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h9ABC_DEF0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0}
	};

	cave_automaton_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cells_in  (cells_in),
		.first_row (first_row),
		.last_row  (last_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cells_out (cells_out),
		.final_row (final_row)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Next generation of one row; cells off the map edge count as alive.
	function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] dn);
		logic [ROW_W+1:0] u;
		logic [ROW_W+1:0] m;
		logic [ROW_W+1:0] d;
		logic [ROW_W-1:0] res;
		int cnt;
		u = {1'b1, up, 1'b1};
		m = {1'b1, mid, 1'b1};
		d = {1'b1, dn, 1'b1};
		for (int k = 0; k < ROW_W; k++) begin
			cnt = int'(u[k]) + int'(u[k+1]) + int'(u[k+2]) + int'(m[k]) + int'(m[k+2])
				+ int'(d[k]) + int'(d[k+1]) + int'(d[k+2]);
			if (m[k+1])
				res[k] = (cnt >= int'(lim_death));
			else
				res[k] = (cnt > int'(lim_birth));
		end
		return res;
	endfunction

	task automatic clear_map();
		row_up   = '1;
		row_held = '0;
		held_ok  = 1'b0;
		held_top = 1'b0;
	endtask

	// Advances the predictor by one accepted row and queues the rows it finishes.
	task automatic predict_row(input row_item_t r);
		result_t res;
		logic [ROW_W-1:0] above_cur;
		if (r.first || !held_ok) begin
			above_cur = '1;
			held_top  = 1'b1;
		end else begin
			res.cells     = evolve_row(held_top ? '1 : row_up, row_held, r.cells);
			res.final_row = 1'b0;
			pending_rows.push_back(res);
			above_cur = row_held;
			held_top  = 1'b0;
		end
		if (r.last) begin
			res.cells     = evolve_row(above_cur, r.cells, '1);
			res.final_row = 1'b1;
			pending_rows.push_back(res);
			clear_map();
		end else begin
			row_up   = above_cur;
			row_held = r.cells;
			held_ok  = 1'b1;
		end
		if (r.typed) begin
			res.cells     = r.exp_cells;
			res.final_row = r.exp_final;
			pending_rows[pending_rows.size()-1] = res;
		end
	endtask

	// Offers one row and returns at the edge where the transaction completes.
	task automatic push_row(input row_item_t r);
		logic hit;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cells_in  <= r.cells;
		first_row <= r.first;
		last_row  <= r.last;
		forever begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
			if (hit)
				break;
		end
		predict_row(r);
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0)
			@(posedge clk);
		// A held row may still be in flight even with nothing expected.
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		logic hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(negedge clk);
			hit = cfg_ready;
			@(posedge clk);
			if (hit)
				break;
		end
		cfg_valid <= 1'b0;
		if (idx == REG_DEATH_LIMIT)
			lim_death = val;
		else if (idx == REG_BIRTH_LIMIT)
			lim_birth = val;
	endtask

	task automatic set_limits(input logic [LIMIT_W-1:0] death, input logic [LIMIT_W-1:0] birth);
		wait_drained();
		cfg_write(REG_DEATH_LIMIT, death);
		cfg_write(REG_BIRTH_LIMIT, birth);
	endtask

	function automatic logic [ROW_W-1:0] random_row();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return $urandom();
			3: return $urandom() & $urandom();
			4: return $urandom() | $urandom();
			default: return ROW_W'(1) << $urandom_range(0, ROW_W-1);
		endcase
	endfunction

	// Mostly well-formed maps with random content; the rest are loose rows with random marks.
	task automatic run_maps(input int n_items);
		row_item_t r;
		int sent;
		int len;
		sent = 0;
		r = '0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				r.cells = random_row();
				r.first = 1'($urandom_range(0, 1));
				r.last  = 1'($urandom_range(0, 1));
				push_row(r);
				sent++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					r.cells = random_row();
					r.first = (i == 0);
					r.last  = (i == len - 1);
					push_row(r);
					sent++;
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// Long receiver hold-off while the sender keeps offering rows.
	initial begin
		long_hold = 1'b0;
		wait (hold_req);
		@(negedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		long_hold = 1'b0;
	end

	// Result side: ready is driven at the rising edge, the transaction is sampled at the
	// falling edge before the edge that completes it.
	always begin
		result_t want;
		@(posedge clk);
		out_ready <= !long_hold && ($urandom_range(99) >= out_stall_pct);
		@(negedge clk);
		if (arst_n && out_valid && out_ready) begin
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: cells %h final %b", cells_out, final_row);
			end else begin
				want = pending_rows.pop_front();
				if (cells_out !== want.cells || final_row !== want.final_row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected cells %h final %b, got cells %h final %b",
							want.cells, want.final_row, cells_out, final_row);
				end
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_DEATH_LIMIT;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		cells_in      <= '0;
		first_row     <= 1'b0;
		last_row      <= 1'b0;
		out_ready     <= 1'b0;
		hold_req      = 1'b0;
		mismatches    = 0;
		cycles        = 0;
		in_idle_pct   = 0;
		out_stall_pct = 0;
		lim_death     = DEATH_LIMIT_RST;
		lim_birth     = BIRTH_LIMIT_RST;
		clear_map();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			push_row(directed_rows[i]);
		in_valid <= 1'b0;

		set_limits(4'd0, 4'd8);
		run_maps(PHASE_ITEMS);

		in_idle_pct = 50;
		set_limits(4'd9, 4'd0);
		run_maps(PHASE_ITEMS);

		in_idle_pct   = 0;
		out_stall_pct = 50;
		wait_drained();
		cfg_write(REG_SPARE, 4'hF);
		set_limits(4'd6, 4'd7);
		run_maps(PHASE_ITEMS);

		in_idle_pct   = 12;
		out_stall_pct = 12;
		set_limits(4'd2, 4'd5);
		run_maps(PHASE_ITEMS);

		in_idle_pct   = 0;
		out_stall_pct = 0;
		set_limits(DEATH_LIMIT_RST, BIRTH_LIMIT_RST);
		hold_req = 1'b1;
		run_maps(PHASE_ITEMS);

		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && pending_rows.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== cave_automaton_step.f =====
hdl/cas_pkg.sv
hdl/cas_cell.sv
hdl/cas_outq.sv
hdl/cave_automaton_step.sv
hdl/cas_checker.sv
test/tb_cave_automaton_step.sv
